FILE: design/gmnd_pkg.sv
// shared types, constants and helper functions for the grid min-neighbour diffusion block
`default_nettype none

package gmnd_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ROW_BITS   = 6;
  localparam int COL_BITS   = 6;
  localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SIZE_BITS  = 7;
  localparam int PICK_BITS  = 4;
  localparam int COUNT_BITS = 4;
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  // action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_DIFFUSE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WRAP = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // neighbour offset codes
  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  localparam logic [COUNT_BITS-1:0] MAX_TIES = COUNT_BITS'(9);

  typedef struct packed {
    logic [1:0]            action;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] load_value;
    logic [PICK_BITS-1:0]  tie_pick;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] cell_value;
    logic [ROW_BITS-1:0]   min_row;
    logic [COL_BITS-1:0]   min_col;
    logic [COUNT_BITS-1:0] tie_count;
  } res_t;

  typedef struct packed {
    logic                 wrap;
    logic [SIZE_BITS-1:0] rows;
    logic [SIZE_BITS-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic                  busy;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic                  wsel_load;
    logic [VALUE_BITS-1:0] load_value;
    logic                  emit_load;
    logic                  emit_read;
    logic                  emit_diff;
  } ctl_t;

  typedef struct packed {
    logic                 init;
    logic                 sample;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
    logic [PICK_BITS-1:0] pick;
  } scan_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] mean;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic [COUNT_BITS-1:0] count;
  } pick_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_OUT,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE_A,
    ST_WRITE_B
  } state_t;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v,
                                                    input logic [SIZE_BITS-1:0] maxv);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) r = SIZE_BITS'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  function automatic logic [ROW_BITS-1:0] clamp_idx(input logic [ROW_BITS-1:0] v,
                                                    input logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS-1:0] last;
    last = size - SIZE_BITS'(1);
    return ({1'b0, v} >= size) ? last[ROW_BITS-1:0] : v;
  endfunction

  // neighbour coordinate with wrap or fall back to centre at the edges
  function automatic logic [ROW_BITS-1:0] neighbour(input logic [ROW_BITS-1:0] c,
                                                    input logic [1:0] off,
                                                    input logic [SIZE_BITS-1:0] size,
                                                    input logic wrap);
    logic [SIZE_BITS-1:0] last;
    logic [SIZE_BITS-1:0] up;
    logic [ROW_BITS-1:0]  r;
    last = size - SIZE_BITS'(1);
    up   = {1'b0, c} + SIZE_BITS'(1);
    r    = c;
    if (off == OFF_NEG) begin
      if (c == '0) r = wrap ? last[ROW_BITS-1:0] : c;
      else r = c - ROW_BITS'(1);
    end else if (off == OFF_POS) begin
      if (up >= size) r = wrap ? '0 : c;
      else r = up[ROW_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ROW_BITS-1:0] row,
                                                     input logic [COL_BITS-1:0] col);
    return {row, col};
  endfunction

endpackage

`default_nettype wire

FILE: design/grid_min_neighbour_diffusion_unit.sv
// top level: config registers, grid memory, sequencer, compare unit and result register
// busy from an accepted start until the done strobe; the next start may come in the done cycle
// a diffuse takes one centre read, nine neighbour reads and two write-backs on the single ram port
// rst is synchronous: control, sizes (64x64) and wrap mode reset; grid contents stay undefined
// results are strobed on done for one cycle and the receiver cannot stall
`default_nettype none

module grid_min_neighbour_diffusion_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire gmnd_pkg::cmd_t                  cmd,
  output logic                                 done,
  output gmnd_pkg::res_t                       result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gmnd_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [gmnd_pkg::PDATA_BITS-1:0] pwdata,
  output logic      [gmnd_pkg::PDATA_BITS-1:0] prdata,
  output logic                                 pready
);

  gmnd_pkg::cfg_t                  cfg;
  gmnd_pkg::ctl_t                  ctl;
  gmnd_pkg::scan_t                 scan;
  gmnd_pkg::pick_t                 pk;
  logic [gmnd_pkg::VALUE_BITS-1:0] rdata;
  logic [gmnd_pkg::VALUE_BITS-1:0] wdata;
  logic [1:0]                      reg_idx;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap <= 1'b0;
      cfg.rows <= gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_ROWS);
      cfg.cols <= gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_COLS);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gmnd_pkg::REG_WRAP: cfg.wrap <= pwdata[0];
        gmnd_pkg::REG_ROWS: cfg.rows <= pwdata[gmnd_pkg::SIZE_BITS-1:0];
        gmnd_pkg::REG_COLS: cfg.cols <= pwdata[gmnd_pkg::SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gmnd_pkg::REG_WRAP: prdata = gmnd_pkg::PDATA_BITS'(cfg.wrap);
      gmnd_pkg::REG_ROWS: prdata = gmnd_pkg::PDATA_BITS'(cfg.rows);
      gmnd_pkg::REG_COLS: prdata = gmnd_pkg::PDATA_BITS'(cfg.cols);
      default:            prdata = '0;
    endcase
  end

  gmnd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .cfg   (cfg),
    .pk    (pk),
    .ctl   (ctl),
    .scan  (scan)
  );

  assign wdata = ctl.wsel_load ? ctl.load_value : pk.mean;

  gmnd_grid_ram u_ram (
    .clk   (clk),
    .we    (ctl.mem_we),
    .addr  (ctl.mem_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  gmnd_min_track u_track (
    .clk   (clk),
    .rst   (rst),
    .scan  (scan),
    .rdata (rdata),
    .pk    (pk)
  );

  assign busy = ctl.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit_load || ctl.emit_read || ctl.emit_diff;
    end
    if (ctl.emit_load) begin
      result <= '{cell_value: ctl.load_value, min_row: '0, min_col: '0, tie_count: '0};
    end else if (ctl.emit_read) begin
      result <= '{cell_value: rdata, min_row: '0, min_col: '0, tie_count: '0};
    end else if (ctl.emit_diff) begin
      result <= '{cell_value: pk.mean, min_row: pk.row, min_col: pk.col, tie_count: pk.count};
    end
  end

  // an accepted transfer always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not make the block busy");

  // a result is only presented once the sequencer is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // grid is written only from within a command
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.mem_we |-> busy)
    else $error("grid write outside a command");

  // a diffuse result always lists between one and nine minima
  a_tie_count: assert property (@(posedge clk) disable iff (rst)
    $past(ctl.emit_diff) && done |-> result.tie_count >= 4'd1 && result.tie_count <= 4'd9)
    else $error("tie count out of range");

endmodule

`default_nettype wire

FILE: design/gmnd_grid_ram.sv
// single-port grid memory with registered read data
`default_nettype none

module gmnd_grid_ram (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [gmnd_pkg::ADDR_BITS-1:0]  addr,
  input  wire logic [gmnd_pkg::VALUE_BITS-1:0] wdata,
  output logic      [gmnd_pkg::VALUE_BITS-1:0] rdata
);

  logic [gmnd_pkg::VALUE_BITS-1:0] mem [gmnd_pkg::GRID_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: design/gmnd_min_track.sv
// running minimum compare unit with tie selection and mean
`default_nettype none

module gmnd_min_track (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire gmnd_pkg::scan_t                 scan,
  input  wire logic [gmnd_pkg::VALUE_BITS-1:0] rdata,
  output gmnd_pkg::pick_t                      pk
);

  logic                              tag_init;
  logic                              tag_sample;
  logic [gmnd_pkg::ROW_BITS-1:0]     tag_row;
  logic [gmnd_pkg::COL_BITS-1:0]     tag_col;
  logic [gmnd_pkg::PICK_BITS-1:0]    pick;
  logic [gmnd_pkg::VALUE_BITS-1:0]   centre;
  logic [gmnd_pkg::VALUE_BITS-1:0]   mn;
  logic [gmnd_pkg::COUNT_BITS-1:0]   cnt;
  logic [gmnd_pkg::ROW_BITS-1:0]     sel_row;
  logic [gmnd_pkg::COL_BITS-1:0]     sel_col;

  // tag is registered alongside the read address, matching the registered ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_init   <= 1'b0;
      tag_sample <= 1'b0;
    end else begin
      tag_init   <= scan.init;
      tag_sample <= scan.sample;
    end
    tag_row <= scan.row;
    tag_col <= scan.col;
    if (scan.init) begin
      pick <= scan.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_init) begin
      centre <= rdata;
      mn     <= rdata;
      cnt    <= '0;
    end else if (tag_sample) begin
      if (rdata < mn) begin
        mn      <= rdata;
        cnt     <= gmnd_pkg::COUNT_BITS'(1);
        sel_row <= tag_row;
        sel_col <= tag_col;
      end else if (rdata == mn && cnt < gmnd_pkg::MAX_TIES) begin
        cnt <= cnt + gmnd_pkg::COUNT_BITS'(1);
        // later entries up to the pick overwrite, so the pick clamps to the last
        if (cnt <= pick) begin
          sel_row <= tag_row;
          sel_col <= tag_col;
        end
      end
    end
  end

  assign pk.mean  = (centre >> 1) + (mn >> 1) +
                    gmnd_pkg::VALUE_BITS'(centre[0] & mn[0]);
  assign pk.row   = sel_row;
  assign pk.col   = sel_col;
  assign pk.count = cnt;

endmodule

`default_nettype wire

FILE: design/gmnd_ctrl.sv
// sequencer: command latch, neighbourhood scan and write-back
`default_nettype none

module gmnd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire gmnd_pkg::cmd_t  cmd,
  input  wire gmnd_pkg::cfg_t  cfg,
  input  wire gmnd_pkg::pick_t pk,
  output gmnd_pkg::ctl_t       ctl,
  output gmnd_pkg::scan_t      scan
);

  gmnd_pkg::state_t                 state;
  gmnd_pkg::state_t                 state_next;
  logic [1:0]                       off_r;
  logic [1:0]                       off_r_next;
  logic [1:0]                       off_c;
  logic [1:0]                       off_c_next;
  logic [gmnd_pkg::ROW_BITS-1:0]    cur_row;
  logic [gmnd_pkg::COL_BITS-1:0]    cur_col;
  logic [gmnd_pkg::VALUE_BITS-1:0]  load_value;
  logic [gmnd_pkg::PICK_BITS-1:0]   pick;
  logic [gmnd_pkg::SIZE_BITS-1:0]   nr;
  logic [gmnd_pkg::SIZE_BITS-1:0]   nc;
  logic [gmnd_pkg::ROW_BITS-1:0]    nb_row;
  logic [gmnd_pkg::COL_BITS-1:0]    nb_col;
  logic                             accept;
  logic                             scan_last;

  assign nr        = gmnd_pkg::eff_size(cfg.rows, gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_ROWS));
  assign nc        = gmnd_pkg::eff_size(cfg.cols, gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_COLS));
  assign accept    = start && (state == gmnd_pkg::ST_IDLE);
  assign nb_row    = gmnd_pkg::neighbour(cur_row, off_r, nr, cfg.wrap);
  assign nb_col    = gmnd_pkg::neighbour(cur_col, off_c, nc, cfg.wrap);
  assign scan_last = (off_r == gmnd_pkg::OFF_POS) && (off_c == gmnd_pkg::OFF_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmnd_pkg::ST_IDLE;
      off_r <= gmnd_pkg::OFF_NEG;
      off_c <= gmnd_pkg::OFF_NEG;
    end else begin
      state <= state_next;
      off_r <= off_r_next;
      off_c <= off_c_next;
    end
    if (accept) begin
      cur_row    <= gmnd_pkg::clamp_idx(cmd.row, nr);
      cur_col    <= gmnd_pkg::clamp_idx(cmd.col, nc);
      load_value <= cmd.load_value;
      pick       <= cmd.tie_pick;
    end
  end

  // next state and scan offsets
  always_comb begin
    state_next = state;
    off_r_next = off_r;
    off_c_next = off_c;
    unique case (state)
      gmnd_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.action == gmnd_pkg::ACT_LOAD) state_next = gmnd_pkg::ST_LOAD;
          else if (cmd.action == gmnd_pkg::ACT_DIFFUSE) state_next = gmnd_pkg::ST_CENTER;
          else state_next = gmnd_pkg::ST_READ;
        end
      end
      gmnd_pkg::ST_LOAD:     state_next = gmnd_pkg::ST_IDLE;
      gmnd_pkg::ST_READ:     state_next = gmnd_pkg::ST_READ_OUT;
      gmnd_pkg::ST_READ_OUT: state_next = gmnd_pkg::ST_IDLE;
      gmnd_pkg::ST_CENTER: begin
        off_r_next = gmnd_pkg::OFF_NEG;
        off_c_next = gmnd_pkg::OFF_NEG;
        state_next = gmnd_pkg::ST_SCAN;
      end
      gmnd_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = gmnd_pkg::ST_DRAIN;
        end else if (off_c == gmnd_pkg::OFF_POS) begin
          off_c_next = gmnd_pkg::OFF_NEG;
          off_r_next = off_r + 2'd1;
        end else begin
          off_c_next = off_c + 2'd1;
        end
      end
      gmnd_pkg::ST_DRAIN:   state_next = gmnd_pkg::ST_WRITE_A;
      gmnd_pkg::ST_WRITE_A: state_next = gmnd_pkg::ST_WRITE_B;
      gmnd_pkg::ST_WRITE_B: state_next = gmnd_pkg::ST_IDLE;
      default:              state_next = gmnd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.busy       = (state != gmnd_pkg::ST_IDLE);
    ctl.mem_we     = 1'b0;
    ctl.mem_addr   = gmnd_pkg::cell_addr(cur_row, cur_col);
    ctl.wsel_load  = 1'b0;
    ctl.load_value = load_value;
    ctl.emit_load  = 1'b0;
    ctl.emit_read  = 1'b0;
    ctl.emit_diff  = 1'b0;
    scan.init      = 1'b0;
    scan.sample    = 1'b0;
    scan.row       = nb_row;
    scan.col       = nb_col;
    scan.pick      = pick;
    unique case (state)
      gmnd_pkg::ST_IDLE: begin
      end
      gmnd_pkg::ST_LOAD: begin
        ctl.mem_we    = 1'b1;
        ctl.wsel_load = 1'b1;
        ctl.emit_load = 1'b1;
      end
      gmnd_pkg::ST_READ: begin
      end
      gmnd_pkg::ST_READ_OUT: begin
        ctl.emit_read = 1'b1;
      end
      gmnd_pkg::ST_CENTER: begin
        scan.init = 1'b1;
      end
      gmnd_pkg::ST_SCAN: begin
        ctl.mem_addr = gmnd_pkg::cell_addr(nb_row, nb_col);
        scan.sample  = 1'b1;
      end
      gmnd_pkg::ST_DRAIN: begin
      end
      gmnd_pkg::ST_WRITE_A: begin
        ctl.mem_we = 1'b1;
      end
      gmnd_pkg::ST_WRITE_B: begin
        ctl.mem_we    = 1'b1;
        ctl.mem_addr  = gmnd_pkg::cell_addr(pk.row, pk.col);
        ctl.emit_diff = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the grid min-neighbour diffusion unit: scoreboard class and stimulus
`timescale 1ns / 1ps

class diffusion_scoreboard;
  logic [gmnd_pkg::VALUE_BITS-1:0] grid [gmnd_pkg::GRID_DEPTH];
  bit loaded [gmnd_pkg::GRID_DEPTH];
  bit wrap;
  bit [gmnd_pkg::SIZE_BITS-1:0] rows_reg;
  bit [gmnd_pkg::SIZE_BITS-1:0] cols_reg;
  gmnd_pkg::res_t pending_results[$];
  int errors;

  function new();
    wrap = 1'b0;
    rows_reg = gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_ROWS);
    cols_reg = gmnd_pkg::SIZE_BITS'(gmnd_pkg::MAX_COLS);
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [gmnd_pkg::PDATA_BITS-1:0] data);
    case (idx)
      gmnd_pkg::REG_WRAP: wrap = data[0];
      gmnd_pkg::REG_ROWS: rows_reg = data[gmnd_pkg::SIZE_BITS-1:0];
      gmnd_pkg::REG_COLS: cols_reg = data[gmnd_pkg::SIZE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function int used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > gmnd_pkg::MAX_ROWS) return gmnd_pkg::MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function int used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > gmnd_pkg::MAX_COLS) return gmnd_pkg::MAX_COLS;
    return int'(cols_reg);
  endfunction

  function int clip(int v, int n);
    return (v >= n) ? n - 1 : v;
  endfunction

  // one coordinate step, wrapping on a torus or staying put at the edge
  function int shift(int c, int off, int n);
    if (off < 0) begin
      if (c == 0) return wrap ? n - 1 : c;
      return c - 1;
    end
    if (off > 0) begin
      if (c + 1 >= n) return wrap ? 0 : c;
      return c + 1;
    end
    return c;
  endfunction

  // grid index of neighbour k (row-major over the 3x3 window, 4 is the centre)
  function int cell_of(int row, int col, int k);
    int r;
    int c;
    r = shift(clip(row, used_rows()), k / 3 - 1, used_rows());
    c = shift(clip(col, used_cols()), k % 3 - 1, used_cols());
    return r * gmnd_pkg::MAX_COLS + c;
  endfunction

  function void apply_cmd(gmnd_pkg::cmd_t c);
    int addr;
    int cnt;
    int pick;
    int maddr;
    int idx;
    int lr [9];
    int lc [9];
    logic [gmnd_pkg::VALUE_BITS-1:0] mn;
    logic [gmnd_pkg::VALUE_BITS-1:0] v;
    logic [gmnd_pkg::VALUE_BITS-1:0] a;
    logic [gmnd_pkg::VALUE_BITS-1:0] b;
    logic [gmnd_pkg::VALUE_BITS-1:0] mean;
    gmnd_pkg::res_t want;
    want = '0;
    addr = cell_of(int'(c.row), int'(c.col), 4);
    if (c.action == gmnd_pkg::ACT_LOAD) begin
      grid[addr] = c.load_value;
      loaded[addr] = 1'b1;
      want.cell_value = c.load_value;
    end else if (c.action == gmnd_pkg::ACT_DIFFUSE) begin
      mn = grid[addr];
      cnt = 0;
      for (int k = 0; k < 9; k++) begin
        idx = cell_of(int'(c.row), int'(c.col), k);
        v = grid[idx];
        if (v < mn) begin
          mn = v;
          cnt = 0;
        end
        if (v == mn) begin
          lr[cnt] = idx / gmnd_pkg::MAX_COLS;
          lc[cnt] = idx % gmnd_pkg::MAX_COLS;
          cnt++;
        end
      end
      pick = int'(c.tie_pick);
      if (pick >= cnt) pick = cnt - 1;
      maddr = lr[pick] * gmnd_pkg::MAX_COLS + lc[pick];
      a = grid[addr];
      b = grid[maddr];
      mean = (a >> 1) + (b >> 1) + gmnd_pkg::VALUE_BITS'(a[0] & b[0]);
      grid[addr] = mean;
      grid[maddr] = mean;
      want.cell_value = mean;
      want.min_row = lr[pick][gmnd_pkg::ROW_BITS-1:0];
      want.min_col = lc[pick][gmnd_pkg::COL_BITS-1:0];
      want.tie_count = cnt[gmnd_pkg::COUNT_BITS-1:0];
    end else begin
      want.cell_value = grid[addr];
    end
    pending_results.insert(pending_results.size(), want);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(gmnd_pkg::res_t got);
    gmnd_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %h with no command outstanding", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.cell_value !== want.cell_value)
      report($sformatf("cell_value got %h want %h", got.cell_value, want.cell_value));
    if (got.min_row !== want.min_row)
      report($sformatf("min_row got %0d want %0d", got.min_row, want.min_row));
    if (got.min_col !== want.min_col)
      report($sformatf("min_col got %0d want %0d", got.min_col, want.min_col));
    if (got.tie_count !== want.tie_count)
      report($sformatf("tie_count got %0d want %0d", got.tie_count, want.tie_count));
  endtask

  function int pending();
    return pending_results.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  gmnd_pkg::cmd_t cmd;
  logic done;
  gmnd_pkg::res_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [gmnd_pkg::PADDR_BITS-1:0] paddr;
  logic [gmnd_pkg::PDATA_BITS-1:0] pwdata;
  logic [gmnd_pkg::PDATA_BITS-1:0] prdata;
  logic pready;

  diffusion_scoreboard grid_check = new();
  int cycles = 0;
  int sent = 0;
  bit gaps_on = 1'b1;

  grid_min_neighbour_diffusion_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) grid_check.check_result(result);
  end

  // present one command and hold it until the transfer
  task automatic send(gmnd_pkg::cmd_t c);
    bit placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if (gaps_on && $urandom_range(99) < 12) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        cmd <= c;
        placed = 1'b1;
      end
    end
    do @(posedge clk); while (busy);
    grid_check.apply_cmd(c);
    sent++;
  endtask

  task automatic send_op(logic [1:0] act, int row, int col, logic [31:0] value, int pick);
    gmnd_pkg::cmd_t c;
    c.action = act;
    c.row = row[gmnd_pkg::ROW_BITS-1:0];
    c.col = col[gmnd_pkg::COL_BITS-1:0];
    c.load_value = value;
    c.tie_pick = pick[gmnd_pkg::PICK_BITS-1:0];
    send(c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [gmnd_pkg::PDATA_BITS-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    grid_check.set_reg(idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (grid_check.pending() != 0) @(posedge clk);
  endtask

  // small values most of the time so that ties show up
  function automatic logic [31:0] rand_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return 32'($urandom_range(3));
    if (sel < 60) return 32'($urandom_range(3)) << 16;
    if (sel < 65) return 32'hFFFF_FFFF;
    if (sel < 70) return 32'h0;
    return $urandom;
  endfunction

  function automatic int pick_coord(int n);
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(n - 1);
  endfunction

  // load cell k of the window first if it was never written
  task automatic ensure_cell(int row, int col, int k);
    int addr;
    addr = grid_check.cell_of(row, col, k);
    if (!grid_check.loaded[addr])
      send_op(gmnd_pkg::ACT_LOAD, addr / gmnd_pkg::MAX_COLS, addr % gmnd_pkg::MAX_COLS,
              rand_value(), $urandom_range(15));
  endtask

  task automatic ensure_area(int row, int col);
    for (int k = 0; k < 9; k++) ensure_cell(row, col, k);
  endtask

  task automatic random_op();
    int r;
    int c;
    int sel;
    r = pick_coord(grid_check.used_rows());
    c = pick_coord(grid_check.used_cols());
    sel = $urandom_range(99);
    if (sel < 15) begin
      send_op(gmnd_pkg::ACT_LOAD, r, c, rand_value(), $urandom_range(15));
    end else if (sel < 32) begin
      ensure_cell(r, c, 4);
      send_op((sel < 28) ? gmnd_pkg::ACT_READ : ACT_SPARE, r, c, $urandom,
              $urandom_range(15));
    end else begin
      ensure_area(r, c);
      send_op(gmnd_pkg::ACT_DIFFUSE, r, c, $urandom,
              ($urandom_range(9) < 6) ? $urandom_range(8) : $urandom_range(15));
    end
  endtask

  task automatic run_phase(bit w, int rows, int cols, int quota, bit gaps);
    int stop;
    drain();
    write_reg(gmnd_pkg::REG_WRAP, 32'(w));
    write_reg(gmnd_pkg::REG_ROWS, 32'(rows));
    write_reg(gmnd_pkg::REG_COLS, 32'(cols));
    gaps_on = gaps;
    stop = sent + quota;
    while (sent < stop) random_op();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every action, clamped edges, ties and clamped picks
    send_op(gmnd_pkg::ACT_LOAD, 0, 0, 32'hFFFF_FFFF, 0);
    send_op(gmnd_pkg::ACT_READ, 0, 0, 32'h0, 15);
    send_op(gmnd_pkg::ACT_LOAD, 63, 63, 32'h0, 15);
    send_op(ACT_SPARE, 63, 63, 32'hFFFF_FFFF, 15);
    send_op(gmnd_pkg::ACT_LOAD, 0, 1, 32'hFFFF_FFFF, 0);
    send_op(gmnd_pkg::ACT_LOAD, 1, 0, 32'hFFFF_FFFF, 0);
    send_op(gmnd_pkg::ACT_LOAD, 1, 1, 32'hFFFF_FFFF, 0);
    // corner without wrap: all nine entries equal
    send_op(gmnd_pkg::ACT_DIFFUSE, 0, 0, 32'h0, 15);
    send_op(gmnd_pkg::ACT_DIFFUSE, 0, 0, 32'hFFFF_FFFF, 0);
    ensure_area(63, 63);
    send_op(gmnd_pkg::ACT_DIFFUSE, 63, 63, $urandom, 8);
    drain();
    write_reg(gmnd_pkg::REG_WRAP, 32'd1);
    write_reg(gmnd_pkg::REG_COLS, 32'd2);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    // column index beyond the used width clamps, window wraps on both axes
    ensure_area(63, 63);
    send_op(gmnd_pkg::ACT_DIFFUSE, 63, 63, 32'h0, 3);
    ensure_cell(40, 63, 4);
    send_op(gmnd_pkg::ACT_READ, 40, 63, $urandom, 0);

    run_phase(1'b1, 64, 64, 250, 1'b1);
    run_phase(1'b0, 1, 1, 150, 1'b1);
    run_phase(1'b1, 1, 64, 150, 1'b1);
    run_phase(1'b0, 0, 127, 150, 1'b1);
    run_phase(1'b1, 127, 0, 150, 1'b1);
    run_phase(1'b1, 3, 3, 250, 1'b0);
    run_phase(1'b0, 2, 5, 200, 1'b1);
    run_phase(1'b1, 5, 2, 200, 1'b1);
    run_phase(1'b0, 8, 8, 250, 1'b1);
    run_phase(1'b1, 64, 64, 250, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (grid_check.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
